>>> rtl/hap_pkg.sv
// Shared constants, types and the coefficient selector for the Hilbert allpass pair.
// Used by hap_serial_mac, hilbert_allpass_pair and the testbench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package hap_pkg;

  // Filter structure.
  localparam int SECTIONS_PER_CHAIN = 6;
  localparam int NUM_SECTIONS       = 2 * SECTIONS_PER_CHAIN;
  localparam int COEF_COUNT         = 12;

  // Number formats.
  localparam int SAMPLE_BITS = 16;
  localparam int STORE_BITS  = 24;
  localparam int COEF_BITS   = 16;
  localparam int COEF_FRAC   = 15;
  localparam int DIFF_BITS   = STORE_BITS + 1;
  localparam int ACC_BITS    = DIFF_BITS + 1;
  localparam int QUOT_BITS   = ACC_BITS + 1;
  localparam int SUM_BITS    = QUOT_BITS + 1;

  // Index and counter widths.
  localparam int SEC_W  = $clog2(NUM_SECTIONS);
  localparam int STEP_W = $clog2(COEF_BITS);

  // Configuration port.
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 64;
  localparam int COEF_WORDS     = 3;
  localparam int COEFS_PER_WORD = CFG_DATA_W / COEF_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE = 2'd0,
    CFG_COEF_0 = 2'd1,
    CFG_COEF_1 = 2'd2,
    CFG_COEF_2 = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_MUL,
    ST_FIN,
    ST_DONE
  } state_t;

  // Control of the serial multiplier.
  typedef struct packed {
    logic load;
    logic step;
    logic last;
  } mac_ctrl_t;

  typedef logic [COEF_WORDS-1:0][CFG_DATA_W-1:0] coef_bank_t;

  // Picks the Q1.15 coefficient of a section; sections beyond the table use zero.
  function automatic logic signed [COEF_BITS-1:0] coef_of(input coef_bank_t bank,
                                                          input logic [SEC_W-1:0] k);
    logic signed [COEF_BITS-1:0] c;
    c = '0;
    for (int i = 0; i < COEF_COUNT; i++) begin
      if (32'(k) == i) begin
        c = bank[i / COEFS_PER_WORD][(i % COEFS_PER_WORD) * COEF_BITS +: COEF_BITS];
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/hap_serial_mac.sv
// Serial-parallel multiplier: one coef bit per step cycle, product shifted out LSB first.
// Depends on hap_pkg for widths and the control struct.
`timescale 1ns / 1ps
`default_nettype none

module hap_serial_mac (
  input  wire logic                                  clk,
  input  wire hap_pkg::mac_ctrl_t                    ctrl,
  input  wire logic signed [hap_pkg::DIFF_BITS-1:0]  d_in,
  input  wire logic signed [hap_pkg::COEF_BITS-1:0]  coef_in,
  output logic signed [hap_pkg::ACC_BITS-1:0]        prod_hi,
  output logic        [1:0]                          prod_lo
);

  logic signed [hap_pkg::DIFF_BITS-1:0] d_r;
  logic        [hap_pkg::COEF_BITS-1:0] cbits_r;
  logic signed [hap_pkg::ACC_BITS-1:0]  acc_r;
  logic        [1:0]                    low_r;

  logic signed [hap_pkg::ACC_BITS:0]    pp;
  logic signed [hap_pkg::ACC_BITS:0]    sum;

  // Partial product for the current coefficient bit; the sign bit weighs negative.
  always_comb begin
    if (!cbits_r[0]) begin
      pp = '0;
    end else if (ctrl.last) begin
      pp = -(hap_pkg::ACC_BITS + 1)'(d_r);
    end else begin
      pp = (hap_pkg::ACC_BITS + 1)'(d_r);
    end
    sum = (hap_pkg::ACC_BITS + 1)'(acc_r) + pp;
  end

  // Accumulate and shift right; the two last bits shifted out are product bits 15 and 14.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      d_r     <= d_in;
      cbits_r <= coef_in;
      acc_r   <= '0;
      low_r   <= '0;
    end else if (ctrl.step) begin
      acc_r   <= sum[hap_pkg::ACC_BITS:1];
      low_r   <= {sum[0], low_r[1]};
      cbits_r <= {1'b0, cbits_r[hap_pkg::COEF_BITS-1:1]};
    end
  end

  assign prod_hi = acc_r;
  assign prod_lo = low_r;

endmodule

`default_nettype wire

>>> rtl/hilbert_allpass_pair.sv
// Hilbert transformer: two cascades of six first-order allpass sections on one serial multiplier.
// Depends on hap_pkg and hap_serial_mac.
// Each section runs history read, operand load, 16 multiply steps and finish, in that order.
// Enabled: the next input is accepted only after the result is loaded into the output register.
// Disabled: outputs are zero, with no section work. Reset sets enable, zeroes the coefficients
// and clears the history valid bits so that all section history reads as zero.
`timescale 1ns / 1ps
`default_nettype none

module hilbert_allpass_pair (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [hap_pkg::SAMPLE_BITS-1:0] in_sample_in,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [hap_pkg::SAMPLE_BITS-1:0]      out_real_out,
  output logic signed [hap_pkg::SAMPLE_BITS-1:0]      out_imag_out,
  input  wire logic                                   cfg_we,
  input  wire logic [hap_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  wire logic [hap_pkg::CFG_DATA_W-1:0]         cfg_wdata
);

  localparam int SB = hap_pkg::STORE_BITS;

  hap_pkg::state_t state_r, state_nxt;

  logic                                  enable_r;
  hap_pkg::coef_bank_t                   coef_r;
  logic [hap_pkg::SEC_W-1:0]             sec_r;
  logic [hap_pkg::STEP_W-1:0]            step_r;
  logic signed [SB-1:0]                  x_r;
  logic signed [SB-1:0]                  x1_r;
  logic signed [hap_pkg::SAMPLE_BITS-1:0] samp_r;
  logic signed [hap_pkg::SAMPLE_BITS-1:0] res_re_r, res_im_r;
  logic signed [hap_pkg::SAMPLE_BITS-1:0] out_re_r, out_im_r;
  logic                                  out_valid_r;

  logic [2*SB-1:0]                       hist_mem [hap_pkg::NUM_SECTIONS];
  logic [hap_pkg::NUM_SECTIONS-1:0]      hist_vld_r;
  logic [2*SB-1:0]                       hist_rd_r;
  logic                                  hist_rd_vld_r;

  hap_pkg::mac_ctrl_t                    mac_ctrl;
  logic signed [hap_pkg::DIFF_BITS-1:0]  mac_d;
  logic signed [hap_pkg::ACC_BITS-1:0]   mac_hi;
  logic        [1:0]                     mac_lo;

  logic                                  in_acc;
  logic                                  hist_we;
  logic                                  out_load;
  logic                                  step_last;
  logic signed [SB-1:0]                  y1_rd;
  logic signed [SB-1:0]                  x1_rd;
  logic signed [hap_pkg::QUOT_BITS-1:0]  quot;
  logic signed [hap_pkg::SUM_BITS-1:0]   y_wide;
  logic signed [SB-1:0]                  y_sec;
  logic signed [SB-1:0]                  samp_ext;

  // Saturate the section sum to the history width.
  function automatic logic signed [SB-1:0] sat_store(input logic signed [hap_pkg::SUM_BITS-1:0] v);
    logic [hap_pkg::SUM_BITS-SB:0] hi;
    hi = v[hap_pkg::SUM_BITS-1:SB-1];
    if (&hi || ~|hi) begin
      return v[SB-1:0];
    end
    return v[hap_pkg::SUM_BITS-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
  endfunction

  // Saturate a cascade output to the sample width.
  function automatic logic signed [hap_pkg::SAMPLE_BITS-1:0] sat_sample(
      input logic signed [SB-1:0] v);
    logic [SB-hap_pkg::SAMPLE_BITS:0] hi;
    hi = v[SB-1:hap_pkg::SAMPLE_BITS-1];
    if (&hi || ~|hi) begin
      return v[hap_pkg::SAMPLE_BITS-1:0];
    end
    return v[SB-1] ? {1'b1, {(hap_pkg::SAMPLE_BITS-1){1'b0}}}
                   : {1'b0, {(hap_pkg::SAMPLE_BITS-1){1'b1}}};
  endfunction

  assign in_stall     = (state_r != hap_pkg::ST_IDLE);
  assign in_acc       = in_valid && !in_stall;
  assign out_valid    = out_valid_r;
  assign out_real_out = out_re_r;
  assign out_imag_out = out_im_r;
  assign step_last    = (step_r == hap_pkg::STEP_W'(hap_pkg::COEF_BITS - 1));

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1;
      coef_r   <= '0;
    end else if (cfg_we) begin
      unique case (hap_pkg::cfg_idx_t'(cfg_index))
        hap_pkg::CFG_ENABLE: enable_r  <= cfg_wdata[0];
        hap_pkg::CFG_COEF_0: coef_r[0] <= cfg_wdata;
        hap_pkg::CFG_COEF_1: coef_r[1] <= cfg_wdata;
        hap_pkg::CFG_COEF_2: coef_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hap_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and control outputs.
  always_comb begin
    state_nxt     = state_r;
    mac_ctrl.load = 1'b0;
    mac_ctrl.step = 1'b0;
    mac_ctrl.last = 1'b0;
    hist_we       = 1'b0;
    out_load      = 1'b0;
    unique case (state_r)
      hap_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = enable_r ? hap_pkg::ST_READ : hap_pkg::ST_DONE;
        end
      end
      hap_pkg::ST_READ: begin
        state_nxt = hap_pkg::ST_LOAD;
      end
      hap_pkg::ST_LOAD: begin
        mac_ctrl.load = 1'b1;
        state_nxt     = hap_pkg::ST_MUL;
      end
      hap_pkg::ST_MUL: begin
        mac_ctrl.step = 1'b1;
        mac_ctrl.last = step_last;
        if (step_last) begin
          state_nxt = hap_pkg::ST_FIN;
        end
      end
      hap_pkg::ST_FIN: begin
        hist_we = 1'b1;
        if (sec_r == hap_pkg::SEC_W'(hap_pkg::NUM_SECTIONS - 1)) begin
          state_nxt = hap_pkg::ST_DONE;
        end else begin
          state_nxt = hap_pkg::ST_READ;
        end
      end
      hap_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = hap_pkg::ST_IDLE;
        end
      end
      default: state_nxt = hap_pkg::ST_IDLE;
    endcase
  end

  // Section history store; entries never written read as zero through the valid bits.
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[sec_r] <= {x_r, y_sec};
    end
    hist_rd_r <= hist_mem[sec_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r    <= '0;
      hist_rd_vld_r <= 1'b0;
    end else begin
      if (hist_we) begin
        hist_vld_r[sec_r] <= 1'b1;
      end
      hist_rd_vld_r <= hist_vld_r[sec_r];
    end
  end

  // Operands of the current section.
  assign x1_rd    = hist_rd_vld_r ? hist_rd_r[2*SB-1:SB] : '0;
  assign y1_rd    = hist_rd_vld_r ? hist_rd_r[SB-1:0] : '0;
  assign mac_d    = hap_pkg::DIFF_BITS'(x_r) - hap_pkg::DIFF_BITS'(y1_rd);
  assign samp_ext = SB'(samp_r);

  hap_serial_mac u_mac (
    .clk     (clk),
    .ctrl    (mac_ctrl),
    .d_in    (mac_d),
    .coef_in (hap_pkg::coef_of(coef_r, sec_r)),
    .prod_hi (mac_hi),
    .prod_lo (mac_lo)
  );

  // y = x1 + round(c*(x - y1) / 2^15), rounding half up, then saturated.
  assign quot   = {mac_hi, mac_lo[1]};
  assign y_wide = hap_pkg::SUM_BITS'(quot) + hap_pkg::SUM_BITS'(x1_r)
                + hap_pkg::SUM_BITS'({1'b0, mac_lo[0]});
  assign y_sec  = sat_store(y_wide);

  // Section sequencing and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r  <= '0;
      step_r <= '0;
    end else begin
      if (in_acc) begin
        sec_r <= '0;
      end else if (state_r == hap_pkg::ST_FIN) begin
        sec_r <= sec_r + 1'b1;
      end
      if (state_r == hap_pkg::ST_LOAD) begin
        step_r <= '0;
      end else if (state_r == hap_pkg::ST_MUL) begin
        step_r <= step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      samp_r   <= in_sample_in;
      x_r      <= SB'(in_sample_in);
      res_re_r <= '0;
      res_im_r <= '0;
    end else if (state_r == hap_pkg::ST_LOAD) begin
      x1_r <= x1_rd;
    end else if (state_r == hap_pkg::ST_FIN) begin
      if (sec_r == hap_pkg::SEC_W'(hap_pkg::SECTIONS_PER_CHAIN - 1)) begin
        res_re_r <= sat_sample(y_sec);
        x_r      <= samp_ext;
      end else begin
        x_r <= y_sec;
      end
      if (sec_r == hap_pkg::SEC_W'(hap_pkg::NUM_SECTIONS - 1)) begin
        res_im_r <= sat_sample(y_sec);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_re_r <= res_re_r;
      out_im_r <= res_im_r;
    end
  end

  // A disabled item goes straight to the output stage with zero results.
  a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !enable_r) |=> (state_r == hap_pkg::ST_DONE && res_re_r == '0 && res_im_r == '0))
    else $error("disabled item did not yield zero results");

  // The multiply runs exactly the coefficient width in steps before finishing.
  a_mul_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == hap_pkg::ST_MUL && step_last) |=> (state_r == hap_pkg::ST_FIN))
    else $error("multiply did not end after its last step");

  // History writes stay within the section range.
  a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
    hist_we |-> (sec_r < hap_pkg::SEC_W'(hap_pkg::NUM_SECTIONS)))
    else $error("section index out of range");

endmodule

`default_nettype wire

>>> test/tb.sv
// Self-checking testbench for hilbert_allpass_pair: directed and random samples over
// several coefficient settings, with each result checked against an in-bench predictor.
// Depends on hap_pkg and the hilbert_allpass_pair RTL only.
`timescale 1ns / 1ps

module tb;
  import hap_pkg::*;

  // One result item: both cascade outputs.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] in_phase;
    logic signed [SAMPLE_BITS-1:0] quadrature;
  } iq_pair_t;

  logic                          clk          = 1'b0;
  logic                          rst_n        = 1'b0;
  logic                          in_valid     = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_sample_in = '0;
  logic                          out_valid;
  logic                          out_stall    = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_real_out;
  logic signed [SAMPLE_BITS-1:0] out_imag_out;
  logic                          cfg_we       = 1'b0;
  cfg_idx_t                      cfg_index    = CFG_ENABLE;
  logic [CFG_DATA_W-1:0]         cfg_wdata    = '0;

  // Predictor copy of the registers and of the section history.
  logic                          pred_enable = 1'b1;
  logic [CFG_DATA_W-1:0]         coef_regs [COEF_WORDS] = '{default: '0};
  logic signed [STORE_BITS-1:0]  hist_x [2][SECTIONS_PER_CHAIN] = '{default: '0};
  logic signed [STORE_BITS-1:0]  hist_y [2][SECTIONS_PER_CHAIN] = '{default: '0};

  iq_pair_t iq_expected [$];
  int       fail_count  = 0;
  bit       stall_on    = 1'b1;
  int       stall_left  = 0;

  hilbert_allpass_pair dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample_in (in_sample_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_real_out (out_real_out),
    .out_imag_out (out_imag_out),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Clamps a value to a signed range of the given width.
  function automatic longint saturate(input longint v, input int bits);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  // Runs one sample through both cascades and updates the history.
  function automatic iq_pair_t hilbert_predict(input logic signed [SAMPLE_BITS-1:0] s);
    iq_pair_t r;
    longint   v;
    longint   acc;
    longint   c;
    int       k;
    r = '0;
    if (!pred_enable) return r;
    for (int ch = 0; ch < 2; ch++) begin
      v = s;
      for (int sec = 0; sec < SECTIONS_PER_CHAIN; sec++) begin
        k = ch * SECTIONS_PER_CHAIN + sec;
        // Sections past the coefficient table behave as if their coefficient were zero.
        if (k < COEF_COUNT) begin
          c = longint'($signed(coef_regs[k / COEFS_PER_WORD][(k % COEFS_PER_WORD) * COEF_BITS +:
                                                               COEF_BITS]));
        end else begin
          c = 0;
        end
        acc = c * v + (longint'(hist_x[ch][sec]) <<< COEF_FRAC) - c * longint'(hist_y[ch][sec]);
        hist_x[ch][sec] = STORE_BITS'(v);
        v = saturate((acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC, STORE_BITS);
        hist_y[ch][sec] = STORE_BITS'(v);
      end
      if (ch == 0) begin
        r.in_phase = SAMPLE_BITS'(saturate(v, SAMPLE_BITS));
      end else begin
        r.quadrature = SAMPLE_BITS'(saturate(v, SAMPLE_BITS));
      end
    end
    return r;
  endfunction

  function automatic void log_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $time, msg);
  endfunction

  // Result side: checks each accepted item and stalls in random bursts.
  always @(posedge clk) begin : result_check
    iq_pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (iq_expected.size() == 0) begin
        log_failure($sformatf("result with nothing expected: real %0d imag %0d",
                              out_real_out, out_imag_out));
      end else begin
        want = iq_expected.pop_front();
        if (out_real_out !== want.in_phase)
          log_failure($sformatf("real_out expected %0d, got %0d", want.in_phase, out_real_out));
        if (out_imag_out !== want.quadrature)
          log_failure($sformatf("imag_out expected %0d, got %0d", want.quadrature, out_imag_out));
      end
    end
    if (!rst_n || !stall_on) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Sends one sample, sometimes after a random gap, and records its expected result.
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s);
    if (stall_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    do @(posedge clk); while (in_stall);
    iq_expected.push_back(hilbert_predict(s));
  endtask

  // Stops sending and waits until every expected result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (iq_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_ENABLE) begin
      pred_enable = value[0];
    end else begin
      coef_regs[idx - CFG_COEF_0] = value;
    end
  endtask

  task automatic load_coefs(input logic [CFG_DATA_W-1:0] w0, input logic [CFG_DATA_W-1:0] w1,
                            input logic [CFG_DATA_W-1:0] w2);
    set_register(CFG_COEF_0, w0);
    set_register(CFG_COEF_1, w1);
    set_register(CFG_COEF_2, w2);
  endtask

  // Builds one coefficient word: 0 random, 1 all most positive, 2 all most negative,
  // 3 all zero, 4 each lane picked among the extremes and a random value.
  function automatic logic [CFG_DATA_W-1:0] random_coef_word(input int mode);
    logic [CFG_DATA_W-1:0] w;
    w = {$urandom, $urandom};
    for (int lane = 0; lane < COEFS_PER_WORD; lane++) begin
      case (mode)
        1: w[lane * COEF_BITS +: COEF_BITS] = 16'h7FFF;
        2: w[lane * COEF_BITS +: COEF_BITS] = 16'h8000;
        3: w[lane * COEF_BITS +: COEF_BITS] = 16'h0000;
        4: begin
          case ($urandom_range(0, 3))
            0: w[lane * COEF_BITS +: COEF_BITS] = 16'h7FFF;
            1: w[lane * COEF_BITS +: COEF_BITS] = 16'h8000;
            2: w[lane * COEF_BITS +: COEF_BITS] = 16'h0000;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    return w;
  endfunction

  // Mostly full-range samples, with extremes and values near zero mixed in.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return SAMPLE_BITS'($signed($urandom_range(0, 16)) - 8);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // With zero coefficients after reset, each cascade is a pure six-sample delay.
  task automatic test_reset_defaults();
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    send_sample(16'sh4000);
    send_sample(-16'sh4000);
    send_sample(16'sd12345);
  endtask

  // Only bit 0 of an enable write counts; while disabled the history must hold.
  task automatic test_enable_bit_only();
    drain_results();
    set_register(CFG_ENABLE, 64'hFFFF_FFFF_FFFF_FFFE);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sd777);
    drain_results();
    set_register(CFG_ENABLE, 64'h8000_0000_0000_0001);
    send_sample(16'sd0);
  endtask

  // Coefficients at both ends of the range drive the sections into saturation; a mixed set follows.
  task automatic test_coefficient_extremes();
    drain_results();
    load_coefs({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
    repeat (2) begin
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
    end
    drain_results();
    load_coefs({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
    repeat (2) begin
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);
    end
    send_sample(16'sh7FFF);
    drain_results();
    load_coefs(64'h7A10_5C2E_2E91_0C4F, 64'h8123_B5D0_1F3A_6E02, 64'hD004_43A1_F9C8_7FF0);
    send_sample(16'sd20000);
    send_sample(-16'sd31000);
    send_sample(16'sd5);
  endtask

  // Phases of random samples, each under a fresh configuration set while idle.
  task automatic test_random_phases();
    int mode;
    for (int p = 0; p < 10; p++) begin
      drain_results();
      mode = (p < 3) ? p + 1 : (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
      load_coefs(random_coef_word(mode), random_coef_word(mode), random_coef_word(mode));
      set_register(CFG_ENABLE, {$urandom, 31'($urandom_range(0, 32'h7FFF_FFFF)), 1'b0} |
                               CFG_DATA_W'(p != 4));
      repeat ((p == 4) ? 40 : 210) send_sample(pick_sample());
    end
  endtask

  // Last stretch with neither side idling: items go back to back.
  task automatic test_back_to_back();
    drain_results();
    stall_on = 1'b0;
    load_coefs(random_coef_word(0), random_coef_word(4), random_coef_word(0));
    set_register(CFG_ENABLE, 64'd1);
    repeat (100) send_sample(pick_sample());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_enable_bit_only();
    test_coefficient_extremes();
    test_random_phases();
    test_back_to_back();
    drain_results();
    repeat (240) @(posedge clk);
    if (fail_count == 0 && iq_expected.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Run limit, several times the slowest correct run.
  initial begin
    #25_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
